### rtl/core/char_lcd_nibble_write_sequencer_defines.svh
// ----------------------------------------------------------------------------
// char lcd nibble write sequencer assertion macros
// shared check forms, sampled on clock and off during reset
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// condition holds at every edge
`define LCDNW_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds at the edge after the antecedent
`define LCDNW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds at the same edge as the antecedent
`define LCDNW_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/core/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// types, codes and the power-up table of the character lcd write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

   localparam logic [2:0] OP_INIT        = 3'd0;
   localparam logic [2:0] OP_CMD         = 3'd1;
   localparam logic [2:0] OP_DATA        = 3'd2;
   localparam logic [2:0] OP_CURSOR      = 3'd3;
   localparam logic [2:0] OP_PRINT_INT   = 3'd4;
   localparam logic [2:0] OP_PRINT_ANGLE = 3'd5;

   localparam logic KIND_NIBBLE = 1'b0;
   localparam logic KIND_WAIT   = 1'b1;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   localparam logic [5:0] WAIT_NONE = 6'd0;
   localparam logic [5:0] WAIT_CMD  = 6'd2;
   localparam logic [5:0] WAIT_CHAR = 6'd1;

   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [3:0] DIGIT_ASCII = 4'h3;
   localparam logic [6:0] ROW1_BASE   = 7'h40;
   localparam logic [6:0] ROW0_BASE   = 7'h00;

   localparam int         NUM_DIGITS   = 10;
   localparam int         MAG_BITS     = 32;
   localparam logic [3:0] INIT_LAST    = 4'd13;
   localparam logic [1:0] SPACES_ZERO  = 2'd3;
   localparam logic [1:0] SPACES_OTHER = 2'd1;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_BYTE,
      JOB_PRINT
   } job_kind_type;

   typedef struct packed {
      job_kind_type              kind;
      logic                      rs;
      logic [7:0]                byte_value;
      logic                      neg;
      logic                      zero;
      logic [3:0]                top_digit;
      logic [4*NUM_DIGITS-1:0]   bcd;
   } job_type;

   typedef struct packed {
      logic       kind;
      logic       rs;
      logic [3:0] nibble;
      logic [5:0] wait_ms;
   } item_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_INIT,
      B_BYTE,
      B_SIGN,
      B_DIGIT,
      B_SPACE
   } back_state_type;

   function automatic item_type init_item(input logic [3:0] idx);
      item_type it;
      it = '{kind: KIND_NIBBLE, rs: RS_CMD, nibble: 4'h0, wait_ms: WAIT_NONE};
      unique case (idx)
         4'd0: begin
            it.kind    = KIND_WAIT;
            it.wait_ms = 6'd40;
         end
         4'd1: begin
            it.nibble  = 4'h3;
            it.wait_ms = 6'd5;
         end
         4'd2: begin
            it.nibble  = 4'h3;
            it.wait_ms = 6'd1;
         end
         4'd3: begin
            it.nibble  = 4'h3;
            it.wait_ms = 6'd1;
         end
         4'd4:  it.nibble = 4'h2;
         4'd5:  it.nibble = 4'h2;
         4'd6: begin
            it.nibble  = 4'h8;
            it.wait_ms = WAIT_CMD;
         end
         4'd7:  it.nibble = 4'h0;
         4'd8: begin
            it.nibble  = 4'hC;
            it.wait_ms = WAIT_CMD;
         end
         4'd9:  it.nibble = 4'h0;
         4'd10: begin
            it.nibble  = 4'h6;
            it.wait_ms = WAIT_CMD;
         end
         4'd11: it.nibble = 4'h0;
         4'd12: begin
            it.nibble  = 4'h1;
            it.wait_ms = WAIT_CMD;
         end
         4'd13: begin
            it.kind    = KIND_WAIT;
            it.wait_ms = WAIT_CMD;
         end
         default: it.kind = KIND_WAIT;
      endcase
      return it;
   endfunction

endpackage

`default_nettype wire

### rtl/core/char_lcd_nibble_write_sequencer.sv
// init, command, data and cursor requests pass through the push state, the queue and the back's output register;
// print requests first run the 32-step binary-to-decimal shift loop in the front.
// the front takes a new request only once the last job is pushed, which waits while the queue is full.
// the back pops a job when idle, then sends one word per cycle while rsp_ready is high.
// up to 26 words per request; the back returns to idle between jobs.
// synchronous active-high reset empties the queue and returns both parts to idle.
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// turns display requests into 4-bit character lcd bus words and waits
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [2:0]          req_op,
   input  wire logic [7:0]          req_byte_value,
   input  wire logic                req_row,
   input  wire logic [5:0]          req_col,
   input  wire logic signed [31:0]  req_number,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_kind,
   output logic                     rsp_reg_select,
   output logic [3:0]               rsp_nibble,
   output logic [5:0]               rsp_wait_ms,
   output logic                     rsp_last
);
   import lcdnw_pkg::*;

   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_valid;
   job_type    push_job;
   job_type    pop_job;

   lcdnw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_number     (req_number),
      .q_push         (q_push),
      .q_job          (push_job),
      .q_full         (q_full)
   );

   lcdnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (pop_job)
   );

   lcdnw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (pop_job),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_wait_ms    (rsp_wait_ms),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/core/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front
// takes requests, decodes them into jobs and converts print values to decimal
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [2:0]          req_op,
   input  wire logic [7:0]          req_byte_value,
   input  wire logic                req_row,
   input  wire logic [5:0]          req_col,
   input  wire logic signed [31:0]  req_number,
   output logic                     q_push,
   output lcdnw_pkg::job_type       q_job,
   input  wire logic                q_full
);
   import lcdnw_pkg::*;

   front_state_type              st_ff, st_in;
   job_type                      job_ff, job_in;
   logic [MAG_BITS-1:0]          mag_ff, mag_in;
   logic [4:0]                   step_ff, step_in;
   logic [4*NUM_DIGITS-1:0]      bcd_adj;
   logic [3:0]                   top;
   logic [6:0]                   addr;
   logic [MAG_BITS-1:0]          num_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      job_ff  <= job_in;
      mag_ff  <= mag_in;
      step_ff <= step_in;
   end

   // add-3 correction of every decimal digit
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (job_ff.bcd[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = job_ff.bcd[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = job_ff.bcd[4*i +: 4];
         end
      end
   end

   // most significant nonzero digit
   always_comb begin
      top = 4'd0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (job_ff.bcd[4*i +: 4] != 4'd0) begin
            top = 4'(i);
         end
      end
   end

   assign addr  = (req_row ? ROW1_BASE : ROW0_BASE) + {1'b0, req_col};
   assign num_u = req_number;

   always_comb begin
      st_in     = st_ff;
      job_in    = job_ff;
      mag_in    = mag_ff;
      step_in   = step_ff;
      req_ready = (st_ff == F_IDLE);
      q_push    = 1'b0;
      q_job     = job_ff;
      q_job.top_digit = top;
      q_job.zero      = (job_ff.bcd == '0);

      unique case (st_ff)
         F_IDLE: begin
            if (req_valid) begin
               job_in.rs         = RS_CMD;
               job_in.byte_value = req_byte_value;
               job_in.neg        = 1'b0;
               job_in.zero       = 1'b0;
               job_in.top_digit  = 4'd0;
               job_in.bcd        = '0;
               unique case (req_op)
                  OP_INIT: begin
                     job_in.kind = JOB_INIT;
                     st_in       = F_PUSH;
                  end
                  OP_CMD: begin
                     job_in.kind = JOB_BYTE;
                     st_in       = F_PUSH;
                  end
                  OP_DATA: begin
                     job_in.kind = JOB_BYTE;
                     job_in.rs   = RS_DATA;
                     st_in       = F_PUSH;
                  end
                  OP_CURSOR: begin
                     job_in.kind       = JOB_BYTE;
                     job_in.byte_value = {1'b1, addr};
                     st_in             = F_PUSH;
                  end
                  OP_PRINT_INT, OP_PRINT_ANGLE: begin
                     job_in.kind = JOB_PRINT;
                     job_in.neg  = num_u[MAG_BITS-1];
                     mag_in      = num_u[MAG_BITS-1] ? (~num_u + 1'b1) : num_u;
                     step_in     = 5'(MAG_BITS - 1);
                     st_in       = F_CONV;
                  end
                  default: st_in = F_IDLE;
               endcase
            end
         end
         F_CONV: begin
            job_in.bcd = {bcd_adj[4*NUM_DIGITS-2:0], mag_ff[MAG_BITS-1]};
            mag_in     = {mag_ff[MAG_BITS-2:0], 1'b0};
            step_in    = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               st_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push = 1'b1;
               st_in  = F_IDLE;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/lcdnw_queue.sv
// ----------------------------------------------------------------------------
// lcdnw_queue
// short job queue between the request decoder and the bus sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcdnw_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lcdnw_pkg::job_type  push_job,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output lcdnw_pkg::job_type       pop_job
);
   import lcdnw_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type          entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      n = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `LCDNW_ASSERT_ALWAYS(a_no_overflow, !(push && full), "job pushed into a full queue")
   `LCDNW_ASSERT_ALWAYS(a_no_underflow, !(pop && !pop_valid), "job popped from an empty queue")
   `LCDNW_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

### rtl/core/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back
// walks one job at a time and emits bus words through an output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcdnw_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire lcdnw_pkg::job_type  q_job,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_kind,
   output logic                     rsp_reg_select,
   output logic [3:0]               rsp_nibble,
   output logic [5:0]               rsp_wait_ms,
   output logic                     rsp_last
);
   import lcdnw_pkg::*;

   back_state_type   st_ff, st_in;
   job_type          job_ff, job_in;
   logic [3:0]       icnt_ff, icnt_in;
   logic [3:0]       dcnt_ff, dcnt_in;
   logic [1:0]       scnt_ff, scnt_in;
   logic             half_ff, half_in;
   logic             rsp_valid_ff;
   item_type         rsp_item_ff;
   logic             rsp_last_ff;

   logic             load_en;
   logic             emit;
   logic             item_last;
   item_type         item;
   logic [7:0]       cur_byte;
   logic             cur_rs;
   logic [3:0]       cur_digit;

   assign load_en   = !rsp_valid_ff || rsp_ready;
   assign cur_digit = job_ff.bcd[{dcnt_ff, 2'b00} +: 4];

   always_comb begin
      unique case (st_ff)
         B_SIGN:  cur_byte = CHAR_MINUS;
         B_DIGIT: cur_byte = {DIGIT_ASCII, cur_digit};
         B_SPACE: cur_byte = CHAR_SPACE;
         default: cur_byte = job_ff.byte_value;
      endcase
      cur_rs = (st_ff == B_BYTE) ? job_ff.rs : RS_DATA;
   end

   always_comb begin
      if (st_ff == B_INIT) begin
         item = init_item(icnt_ff);
      end else begin
         item.kind    = KIND_NIBBLE;
         item.rs      = cur_rs;
         item.nibble  = half_ff ? cur_byte[3:0] : cur_byte[7:4];
         item.wait_ms = !half_ff ? WAIT_NONE : (cur_rs ? WAIT_CHAR : WAIT_CMD);
      end
   end

   always_comb begin
      st_in     = st_ff;
      job_in    = job_ff;
      icnt_in   = icnt_ff;
      dcnt_in   = dcnt_ff;
      scnt_in   = scnt_ff;
      half_in   = half_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      item_last = 1'b0;

      unique case (st_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               job_in  = q_job;
               icnt_in = 4'd0;
               half_in = 1'b0;
               dcnt_in = q_job.top_digit;
               scnt_in = q_job.zero ? SPACES_ZERO : SPACES_OTHER;
               unique case (q_job.kind)
                  JOB_INIT: st_in = B_INIT;
                  JOB_BYTE: st_in = B_BYTE;
                  default:  st_in = q_job.neg ? B_SIGN : B_DIGIT;
               endcase
            end
         end
         B_INIT: begin
            if (load_en) begin
               emit    = 1'b1;
               icnt_in = icnt_ff + 4'd1;
               if (icnt_ff == INIT_LAST) begin
                  item_last = 1'b1;
                  st_in     = B_IDLE;
               end
            end
         end
         B_BYTE: begin
            if (load_en) begin
               emit    = 1'b1;
               half_in = !half_ff;
               if (half_ff) begin
                  item_last = 1'b1;
                  st_in     = B_IDLE;
               end
            end
         end
         B_SIGN: begin
            if (load_en) begin
               emit    = 1'b1;
               half_in = !half_ff;
               if (half_ff) begin
                  st_in = B_DIGIT;
               end
            end
         end
         B_DIGIT: begin
            if (load_en) begin
               emit    = 1'b1;
               half_in = !half_ff;
               if (half_ff) begin
                  if (dcnt_ff == 4'd0) begin
                     st_in = B_SPACE;
                  end else begin
                     dcnt_in = dcnt_ff - 4'd1;
                  end
               end
            end
         end
         B_SPACE: begin
            if (load_en) begin
               emit    = 1'b1;
               half_in = !half_ff;
               if (half_ff) begin
                  if (scnt_ff == 2'd0) begin
                     item_last = 1'b1;
                     st_in     = B_IDLE;
                  end else begin
                     scnt_in = scnt_ff - 2'd1;
                  end
               end
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      job_ff  <= job_in;
      icnt_ff <= icnt_in;
      dcnt_ff <= dcnt_in;
      scnt_ff <= scnt_in;
      half_ff <= half_in;
      if (emit) begin
         rsp_item_ff <= item;
         rsp_last_ff <= item_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_item_ff.kind;
   assign rsp_reg_select = rsp_item_ff.rs;
   assign rsp_nibble     = rsp_item_ff.nibble;
   assign rsp_wait_ms    = rsp_item_ff.wait_ms;
   assign rsp_last       = rsp_last_ff;

   `LCDNW_ASSERT_NEXT(a_last_ends_job, emit && item_last, st_ff == B_IDLE, "job kept running after its last word")
   `LCDNW_ASSERT_SAME(a_wait_clean, rsp_valid_ff && rsp_item_ff.kind == KIND_WAIT, rsp_item_ff.rs == RS_CMD && rsp_item_ff.nibble == 4'd0, "wait word drives bus lines")
   `LCDNW_ASSERT_SAME(a_digit_range, st_ff == B_DIGIT, cur_digit <= 4'd9, "decimal digit out of range")

endmodule

`default_nettype wire
